[sv/joystick_stepper_sequencer_unit_macros.svh]
// Assertion macros used by the checker file of the stepper sequencer.
`ifndef JOYSTICK_STEPPER_SEQUENCER_UNIT_MACROS_SVH
`define JOYSTICK_STEPPER_SEQUENCER_UNIT_MACROS_SVH

// Property checked on every clock edge outside of reset.
`define JSS_ASSERT_ACTIVE(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Property checked on every clock edge, reset included.
`define JSS_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

[sv/jss_pkg.sv]
package jss_pkg;

    // Bus clock rate; the step period numerator is 46 times this value.
    localparam int CLOCK_SCALE = 80000000;
    localparam longint unsigned PERIOD_NUM = 64'(CLOCK_SCALE) * 64'd46;

    // Field widths.
    localparam int X_W      = 10;
    localparam int CFG_W    = 16;
    localparam int PERIOD_W = 23;
    localparam int ANGLE_W  = 7;

    // Divider widths: numerator, denominator, product and step counter.
    localparam int NUM_W  = $clog2(PERIOD_NUM + 64'd1);
    localparam int DEN_W  = 15;
    localparam int PROD_W = 16;
    localparam int CNT_W  = $clog2(NUM_W);

    // Joystick thresholds and the linear period law.
    localparam int FWD_LIMIT = 460;
    localparam int REV_LIMIT = 560;
    localparam int SLOPE     = 39;
    localparam int FWD_BASE  = 18400;
    localparam int REV_BASE  = 21380;

    // Position and period limits.
    localparam int FULL_TURN   = 100;
    localparam int PERIOD_MAX  = 23'h7FFFFF;
    localparam int IDLE_RESET  = 16'hFFFF;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_DONE
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic div_step;
        logic load_out;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic step_item;
        logic div_last;
        logic out_free;
    } t_dp_status;

endpackage

[sv/jss_ctrl.sv]
module jss_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  jss_pkg::t_dp_status   i_status,
    output jss_pkg::t_dp_cmd      o_cmd
);

    jss_pkg::t_state r_state;
    jss_pkg::t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= jss_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and datapath commands.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            jss_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state = i_status.step_item ? jss_pkg::ST_DIV : jss_pkg::ST_DONE;
                end
            end
            jss_pkg::ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_last) begin
                    n_state = jss_pkg::ST_DONE;
                end
            end
            jss_pkg::ST_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state = jss_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = jss_pkg::ST_IDLE;
            end
        endcase
    end

    // A new item is taken only between items.
    assign o_in_stall = (r_state != jss_pkg::ST_IDLE);

endmodule

[sv/jss_datapath.sv]
module jss_datapath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [jss_pkg::CFG_W-1:0]     i_cfg_wr_data,
    input  logic [jss_pkg::X_W-1:0]       i_joystick_sample,
    input  logic                          i_out_stall,
    input  jss_pkg::t_dp_cmd              i_cmd,
    output jss_pkg::t_dp_status           o_status,
    output logic                          o_out_valid,
    output logic                          o_coil_a,
    output logic                          o_coil_b,
    output logic                          o_stepped,
    output logic                          o_reverse,
    output logic [jss_pkg::PERIOD_W-1:0]  o_next_period,
    output logic [jss_pkg::ANGLE_W-1:0]   o_angle_steps
);

    // Configuration and motor state.
    logic [jss_pkg::CFG_W-1:0]    r_idle_period;
    logic [1:0]                   r_phase;
    logic [jss_pkg::ANGLE_W-1:0]  r_angle;
    logic                         r_coil_a;
    logic                         r_coil_b;
    logic                         r_out_valid;

    // Working registers of the current item.
    logic                         r_stepped;
    logic                         r_reverse;
    logic [jss_pkg::DEN_W-1:0]    r_den;
    logic [jss_pkg::DEN_W-1:0]    r_rem;
    logic [jss_pkg::NUM_W-1:0]    r_quo;
    logic [jss_pkg::CNT_W-1:0]    r_cnt;

    // Output payload registers.
    logic                         r_out_coil_a;
    logic                         r_out_coil_b;
    logic                         r_out_stepped;
    logic                         r_out_reverse;
    logic [jss_pkg::PERIOD_W-1:0] r_out_period;
    logic [jss_pkg::ANGLE_W-1:0]  r_out_angle;

    logic                         w_fwd;
    logic                         w_rev;
    logic [jss_pkg::PROD_W-1:0]   w_prod;
    logic [jss_pkg::DEN_W-1:0]    w_den;
    logic [jss_pkg::DEN_W:0]      w_trial;
    logic                         w_qbit;
    logic [jss_pkg::DEN_W-1:0]    n_rem;
    logic [jss_pkg::PERIOD_W-1:0] w_period;

    // Classify the sample and form the period denominator.
    assign w_fwd  = (i_joystick_sample < jss_pkg::X_W'(jss_pkg::FWD_LIMIT));
    assign w_rev  = (i_joystick_sample > jss_pkg::X_W'(jss_pkg::REV_LIMIT));
    assign w_prod = jss_pkg::PROD_W'(i_joystick_sample) * jss_pkg::PROD_W'(jss_pkg::SLOPE);
    assign w_den  = w_fwd
        ? jss_pkg::DEN_W'(jss_pkg::PROD_W'(jss_pkg::FWD_BASE) - w_prod)
        : jss_pkg::DEN_W'(w_prod - jss_pkg::PROD_W'(jss_pkg::REV_BASE));

    // One restoring division step: one quotient bit per cycle.
    assign w_trial = {r_rem, r_quo[jss_pkg::NUM_W-1]};
    assign w_qbit  = (w_trial >= {1'b0, r_den});
    assign n_rem   = w_qbit ? jss_pkg::DEN_W'(w_trial - {1'b0, r_den})
                            : w_trial[jss_pkg::DEN_W-1:0];

    // Saturated step period, or the idle period in the dead zone.
    always_comb begin
        if (!r_stepped) begin
            w_period = jss_pkg::PERIOD_W'(r_idle_period);
        end else if (r_quo > jss_pkg::NUM_W'(jss_pkg::PERIOD_MAX)) begin
            w_period = jss_pkg::PERIOD_W'(jss_pkg::PERIOD_MAX);
        end else begin
            w_period = r_quo[jss_pkg::PERIOD_W-1:0];
        end
    end

    // Configuration, motor state and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idle_period <= jss_pkg::CFG_W'(jss_pkg::IDLE_RESET);
            r_phase       <= 2'd0;
            r_angle       <= '0;
            r_coil_a      <= 1'b0;
            r_coil_b      <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_idle_period <= i_cfg_wr_data;
            end
            // Phases 0..3 drive (A,B) = 11, 01, 00, 10.
            if (i_cmd.accept && (w_fwd || w_rev)) begin
                r_coil_a <= ~(r_phase[1] ^ r_phase[0]);
                r_coil_b <= ~r_phase[1];
                if (w_fwd) begin
                    r_phase <= r_phase + 2'd1;
                    r_angle <= (r_angle >= jss_pkg::ANGLE_W'(jss_pkg::FULL_TURN - 1))
                               ? '0 : r_angle + 1'b1;
                end else begin
                    r_phase <= r_phase - 2'd1;
                    r_angle <= (r_angle <= jss_pkg::ANGLE_W'(1))
                               ? jss_pkg::ANGLE_W'(jss_pkg::FULL_TURN) : r_angle - 1'b1;
                end
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Divider registers and the captured item.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_stepped <= w_fwd || w_rev;
            r_reverse <= w_rev;
            r_den     <= w_den;
            r_rem     <= '0;
            r_quo     <= jss_pkg::NUM_W'(jss_pkg::PERIOD_NUM);
            r_cnt     <= jss_pkg::CNT_W'(jss_pkg::NUM_W - 1);
        end else if (i_cmd.div_step) begin
            r_rem <= n_rem;
            r_quo <= {r_quo[jss_pkg::NUM_W-2:0], w_qbit};
            r_cnt <= r_cnt - 1'b1;
        end
    end

    // Output register, loaded once the previous result has been taken.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_coil_a  <= r_coil_a;
            r_out_coil_b  <= r_coil_b;
            r_out_stepped <= r_stepped;
            r_out_reverse <= r_reverse;
            r_out_period  <= w_period;
            r_out_angle   <= r_angle;
        end
    end

    assign o_status.step_item = w_fwd || w_rev;
    assign o_status.div_last  = (r_cnt == '0);
    assign o_status.out_free  = !r_out_valid || !i_out_stall;

    assign o_out_valid   = r_out_valid;
    assign o_coil_a      = r_out_coil_a;
    assign o_coil_b      = r_out_coil_b;
    assign o_stepped     = r_out_stepped;
    assign o_reverse     = r_out_reverse;
    assign o_next_period = r_out_period;
    assign o_angle_steps = r_out_angle;

endmodule

[sv/joystick_stepper_sequencer_unit.sv]
// A stepping sample runs through the 32-bit period divider, one quotient bit per
// cycle; a dead-zone sample skips the divider and goes straight to the output.
// A new sample is taken only once the last one has been loaded into the output register.
// The output register lets a new item start while the last result waits.
// Reset is synchronous, active low: idle period 0xFFFF, phase 0, position 0,
// coils off, no result pending.
module joystick_stepper_sequencer_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [jss_pkg::CFG_W-1:0]     i_cfg_wr_data,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [jss_pkg::X_W-1:0]       i_joystick_sample,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_coil_a,
    output logic                          o_coil_b,
    output logic                          o_stepped,
    output logic                          o_reverse,
    output logic [jss_pkg::PERIOD_W-1:0]  o_next_period,
    output logic [jss_pkg::ANGLE_W-1:0]   o_angle_steps
);

    jss_pkg::t_dp_cmd    w_cmd;
    jss_pkg::t_dp_status w_status;

    // Sequencing of accept, divide and output load.
    jss_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    // Motor state, period divider and output register.
    jss_datapath u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_wr_en       (i_cfg_wr_en),
        .i_cfg_wr_data     (i_cfg_wr_data),
        .i_joystick_sample (i_joystick_sample),
        .i_out_stall       (i_out_stall),
        .i_cmd             (w_cmd),
        .o_status          (w_status),
        .o_out_valid       (o_out_valid),
        .o_coil_a          (o_coil_a),
        .o_coil_b          (o_coil_b),
        .o_stepped         (o_stepped),
        .o_reverse         (o_reverse),
        .o_next_period     (o_next_period),
        .o_angle_steps     (o_angle_steps)
    );

endmodule

[sv/jss_checker.sv]
`include "joystick_stepper_sequencer_unit_macros.svh"

module jss_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_cfg_wr_en,
    input logic [jss_pkg::CFG_W-1:0]     i_cfg_wr_data,
    input logic                          i_in_valid,
    input logic                          o_in_stall,
    input logic [jss_pkg::X_W-1:0]       i_joystick_sample,
    input logic                          o_out_valid,
    input logic                          i_out_stall,
    input logic                          o_coil_a,
    input logic                          o_coil_b,
    input logic                          o_stepped,
    input logic                          o_reverse,
    input logic [jss_pkg::PERIOD_W-1:0]  o_next_period,
    input logic [jss_pkg::ANGLE_W-1:0]   o_angle_steps
);

    // A stalled result stays offered.
    `JSS_ASSERT_ACTIVE(a_out_hold, o_out_valid && i_out_stall |=> o_out_valid, "result dropped under stall")

    // Reset leaves no result pending.
    `JSS_ASSERT_ALWAYS(a_reset_empty, !i_rst_n |=> !o_out_valid, "result pending after reset")

    // Only one item is in work at a time.
    `JSS_ASSERT_ACTIVE(a_one_item, i_in_valid && !o_in_stall |=> o_in_stall, "second item taken while busy")

    // A backward flag only comes with a step.
    `JSS_ASSERT_ACTIVE(a_rev_step, o_out_valid && o_reverse |-> o_stepped, "reverse without step")

    // Position stays within one turn and a step never gives a zero period.
    `JSS_ASSERT_ACTIVE(a_result_range, o_out_valid |-> (o_angle_steps <= jss_pkg::ANGLE_W'(jss_pkg::FULL_TURN)) && (!o_stepped || (o_next_period != '0)), "result out of range")

endmodule

bind joystick_stepper_sequencer_unit jss_checker u_jss_checker (.*);

[tb/joystick_stepper_sequencer_unit_test.sv]
`timescale 1ns / 100ps

module joystick_stepper_sequencer_unit_test;

    // Port widths taken from the RTL package.
    localparam int X_W      = jss_pkg::X_W;
    localparam int CFG_W    = jss_pkg::CFG_W;
    localparam int PERIOD_W = jss_pkg::PERIOD_W;
    localparam int ANGLE_W  = jss_pkg::ANGLE_W;

    // Joystick law, position range and period ceiling, kept apart from the RTL package.
    localparam int unsigned FWD_EDGE      = 460;
    localparam int unsigned REV_EDGE      = 560;
    localparam int unsigned STEP_SLOPE    = 39;
    localparam int unsigned FWD_OFFSET    = 18400;
    localparam int unsigned REV_OFFSET    = 21380;
    localparam int unsigned STEPS_PER_REV = 100;
    localparam longint unsigned TICKS_NUM = 64'd3680000000;
    localparam longint unsigned TICKS_MAX = 64'h7FFFFF;
    localparam logic [CFG_W-1:0] IDLE_AFTER_RESET = 16'hFFFF;

    // Run control: cycles without any transfer before giving up, the long
    // receiver hold-off, the settling time after the last result, and the idle percentage.
    localparam int STALL_LIMIT    = 2000;
    localparam int HOLDOFF_CYCLES = 300;
    localparam int SETTLE_CYCLES  = 40;
    localparam int IDLE_PERCENT   = 30;

    typedef struct packed {
        logic                coil_a;
        logic                coil_b;
        logic                stepped;
        logic                reverse;
        logic [PERIOD_W-1:0] next_period;
        logic [ANGLE_W-1:0]  angle_steps;
    } t_motion_result;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_wr_en = 1'b0;
    logic [CFG_W-1:0]     i_cfg_wr_data = '0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_stall;
    logic [X_W-1:0]       i_joystick_sample = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    logic                 o_coil_a;
    logic                 o_coil_b;
    logic                 o_stepped;
    logic                 o_reverse;
    logic [PERIOD_W-1:0]  o_next_period;
    logic [ANGLE_W-1:0]   o_angle_steps;

    // Shadow of the motor state and the idle period register.
    logic [1:0]           model_phase;
    logic [ANGLE_W-1:0]   model_angle;
    logic                 model_coil_a;
    logic                 model_coil_b;
    logic [CFG_W-1:0]     model_idle_period;

    t_motion_result       pending_results[$];

    bit                   idling_enabled = 1'b1;
    int                   holdoff_request = 0;
    int                   error_count = 0;
    int                   results_checked = 0;
    int                   forward_count = 0;
    int                   backward_count = 0;
    int                   deadzone_count = 0;
    int                   config_writes = 0;
    int                   quiet_cycles = 0;

    joystick_stepper_sequencer_unit dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_wr_en       (i_cfg_wr_en),
        .i_cfg_wr_data     (i_cfg_wr_data),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_joystick_sample (i_joystick_sample),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_coil_a          (o_coil_a),
        .o_coil_b          (o_coil_b),
        .o_stepped         (o_stepped),
        .o_reverse         (o_reverse),
        .o_next_period     (o_next_period),
        .o_angle_steps     (o_angle_steps)
    );

    // Free-running 4 ns clock.
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 0;
    end

    // Timer reference for a given divisor, truncated and clipped to the port width.
    function automatic logic [PERIOD_W-1:0] step_ticks(input longint unsigned divisor);
        longint unsigned quotient;
        if (divisor == 0) begin
            return PERIOD_W'(TICKS_MAX);
        end
        quotient = TICKS_NUM / divisor;
        if (quotient > TICKS_MAX) begin
            quotient = TICKS_MAX;
        end
        return PERIOD_W'(quotient);
    endfunction

    // Advances the shadow motor by one sample and returns the result it must give.
    function automatic t_motion_result predict_motion(input logic [X_W-1:0] sample);
        t_motion_result   res;
        longint unsigned  x;
        x = longint'(sample);
        res = '0;
        if (x < FWD_EDGE || x > REV_EDGE) begin
            // Coils take the pattern of the current phase before it moves on.
            model_coil_a = (model_phase == 2'd0 || model_phase == 2'd3);
            model_coil_b = (model_phase == 2'd0 || model_phase == 2'd1);
            res.stepped = 1'b1;
            if (x < FWD_EDGE) begin
                res.next_period = step_ticks(FWD_OFFSET - STEP_SLOPE * x);
                model_phase = model_phase + 2'd1;
                model_angle = (model_angle + 1 >= STEPS_PER_REV) ? '0 : model_angle + 1'b1;
            end else begin
                res.reverse = 1'b1;
                res.next_period = step_ticks(STEP_SLOPE * x - REV_OFFSET);
                model_phase = model_phase - 2'd1;
                model_angle = (model_angle <= 1) ? ANGLE_W'(STEPS_PER_REV) : model_angle - 1'b1;
            end
        end else begin
            // Dead zone: coils keep their levels, position holds.
            res.next_period = PERIOD_W'(model_idle_period);
        end
        res.coil_a = model_coil_a;
        res.coil_b = model_coil_b;
        res.angle_steps = model_angle;
        return res;
    endfunction

    // Offers one sample, with a random gap before it; valid stays high on return
    // so that a following sample can go out back to back.
    task automatic send_sample(input logic [X_W-1:0] sample);
        int gap;
        gap = 0;
        while (idling_enabled && $urandom_range(99) < IDLE_PERCENT) begin
            gap++;
        end
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_joystick_sample <= sample;
        do begin
            @(posedge i_clk);
        end while (o_in_stall);
        pending_results.push_back(predict_motion(sample));
        if (sample < FWD_EDGE) begin
            forward_count++;
        end else if (sample > REV_EDGE) begin
            backward_count++;
        end else begin
            deadzone_count++;
        end
        @(negedge i_clk);
    endtask

    // Lowers valid, waits for every expected result and lets the block settle.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Writes the idle period; called only with the block drained.
    task automatic write_idle_period(input logic [CFG_W-1:0] value);
        i_cfg_wr_en <= 1'b1;
        i_cfg_wr_data <= value;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        model_idle_period = value;
        config_writes++;
    endtask

    // Random sample: mostly one of the three zones, sometimes a zone edge.
    function automatic logic [X_W-1:0] random_sample();
        int pick;
        pick = $urandom_range(99);
        if (pick < 8) begin
            case ($urandom_range(5))
                0: return X_W'(0);
                1: return X_W'(FWD_EDGE - 1);
                2: return X_W'(FWD_EDGE);
                3: return X_W'(REV_EDGE);
                4: return X_W'(REV_EDGE + 1);
                default: return X_W'(1023);
            endcase
        end else if (pick < 48) begin
            return X_W'($urandom_range(FWD_EDGE - 1, 0));
        end else if (pick < 85) begin
            return X_W'($urandom_range(1023, REV_EDGE + 1));
        end
        return X_W'($urandom_range(REV_EDGE, FWD_EDGE));
    endfunction

    // Compares one field of a result and reports a mismatch.
    task automatic check_field(input string name, input longint expected_val,
                               input longint actual_val);
        if (expected_val != actual_val) begin
            $error("%s mismatch: expected %0d, got %0d", name, expected_val, actual_val);
            error_count++;
        end
    endtask

    // Result side: random stall, plus a long hold-off when one is requested.
    always @(negedge i_clk) begin
        static int holdoff_left = 0;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (holdoff_request > 0) begin
                holdoff_left = holdoff_request;
                holdoff_request = 0;
            end
            if (holdoff_left > 0) begin
                holdoff_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= idling_enabled && ($urandom_range(99) < IDLE_PERCENT);
            end
        end
    end

    // Checks every result transfer against the oldest prediction and watches for a hang.
    always @(posedge i_clk) begin
        t_motion_result exp_res;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (pending_results.size() == 0) begin
                    $error("result transfer with no sample outstanding");
                    error_count++;
                end else begin
                    exp_res = pending_results.pop_front();
                    check_field("coil_a", exp_res.coil_a, o_coil_a);
                    check_field("coil_b", exp_res.coil_b, o_coil_b);
                    check_field("stepped", exp_res.stepped, o_stepped);
                    check_field("reverse", exp_res.reverse, o_reverse);
                    check_field("next_period", exp_res.next_period, o_next_period);
                    check_field("angle_steps", exp_res.angle_steps, o_angle_steps);
                    results_checked++;
                end
            end
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("Timeout: no transfer for %0d cycles", STALL_LIMIT);
                $display("tb: failure");
                $finish;
            end
        end
    end

    // Zone edges, field extremes, and the coils still off before the first step.
    task automatic test_zone_edges();
        send_sample(X_W'(510));
        send_sample(X_W'(FWD_EDGE));
        send_sample(X_W'(0));
        send_sample(X_W'(FWD_EDGE - 1));
        send_sample(X_W'(REV_EDGE));
        send_sample(X_W'(REV_EDGE + 1));
        send_sample(X_W'(1023));
        send_sample(X_W'(1));
        send_sample(X_W'(10'h2AA));
        send_sample(X_W'(10'h155));
        send_sample(X_W'(1022));
        send_sample(X_W'(FWD_EDGE - 2));
        send_sample(X_W'(REV_EDGE + 2));
        send_sample(X_W'(512));
        drain_results();
    endtask

    // Idle period register at both extremes and a random value.
    task automatic test_idle_period();
        write_idle_period('0);
        send_sample(X_W'(FWD_EDGE));
        send_sample(X_W'(REV_EDGE));
        send_sample(X_W'(300));
        send_sample(X_W'(500));
        drain_results();
        write_idle_period(CFG_W'($urandom_range(16'hFFFE, 1)));
        send_sample(X_W'(505));
        send_sample(X_W'(700));
        drain_results();
        write_idle_period(IDLE_AFTER_RESET);
        send_sample(X_W'(530));
        drain_results();
    endtask

    // Enough steps each way for the position to wrap past both ends.
    task automatic test_position_wrap();
        repeat (STEPS_PER_REV + 5) begin
            send_sample(X_W'($urandom_range(FWD_EDGE - 1, 0)));
        end
        repeat (STEPS_PER_REV + 5) begin
            send_sample(X_W'($urandom_range(1023, REV_EDGE + 1)));
        end
        drain_results();
    endtask

    // Receiver holds off long enough that the block fills and stalls its input.
    task automatic test_output_holdoff();
        idling_enabled = 1'b0;
        holdoff_request = HOLDOFF_CYCLES;
        repeat (12) begin
            send_sample(X_W'($urandom_range(REV_EDGE, FWD_EDGE)));
        end
        repeat (6) begin
            send_sample(random_sample());
        end
        idling_enabled = 1'b1;
        drain_results();
    endtask

    // Random traffic in phases, with a new idle period between phases and one
    // phase that runs with no idling on either side.
    task automatic test_random_traffic();
        for (int burst = 0; burst < 5; burst++) begin
            idling_enabled = (burst != 2);
            repeat (100) begin
                send_sample(random_sample());
            end
            drain_results();
            write_idle_period(CFG_W'($urandom_range(16'hFFFF, 0)));
        end
        idling_enabled = 1'b1;
    endtask

    initial begin
        model_phase = '0;
        model_angle = '0;
        model_coil_a = 1'b0;
        model_coil_b = 1'b0;
        model_idle_period = IDLE_AFTER_RESET;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_zone_edges();
        test_idle_period();
        test_position_wrap();
        test_output_holdoff();
        test_random_traffic();
        drain_results();

        $display("Covered %0d samples: %0d forward, %0d backward, %0d in the dead zone.",
                 forward_count + backward_count + deadzone_count, forward_count,
                 backward_count, deadzone_count);
        $display("Checked %0d results across %0d idle period writes, %0d mismatches.",
                 results_checked, config_writes, error_count);
        if (error_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
